// File: hw/rtl/stq_pkg.sv
`timescale 1ns / 1ps

package stq_pkg;

  localparam int unsigned SLOTS_DEF     = 16;
  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned HANDLE_W      = 4;
  localparam int unsigned MAX_HANDLES   = 1 << HANDLE_W;
  localparam int unsigned COUNT_W       = 5;
  localparam int unsigned MS_W          = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned KIND_W        = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSTALL = 2'd0,
    OP_KILL    = 2'd1,
    OP_TICK    = 2'd2
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    K_INSTALLED = 3'd0,
    K_FULL      = 3'd1,
    K_KILLED    = 3'd2,
    K_FIRED     = 3'd3,
    K_TICK_DONE = 3'd4
  } kind_e;

  typedef struct packed {
    logic  load;
    logic  insert;
    logic  kill;
    logic  sub;
    logic  pop;
    logic  emit;
    kind_e kind;
    logic  last;
  } dp_cmd_t;

  typedef struct packed {
    op_e  op;
    logic full;
    logic head_expired;
  } dp_sts_t;

endpackage

// File: hw/rtl/stq_datapath.sv
`timescale 1ns / 1ps

module stq_datapath #(
  parameter int unsigned SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [stq_pkg::OP_W-1:0]       op_i,
  input  logic [stq_pkg::MS_W-1:0]       delay_ms_i,
  input  logic [stq_pkg::HANDLE_W-1:0]   target_handle_i,
  input  logic [stq_pkg::MS_W-1:0]       elapsed_ms_i,
  input  stq_pkg::dp_cmd_t               cmd_i,
  output stq_pkg::dp_sts_t               sts_o,
  output logic                           result_valid_o,
  output logic [stq_pkg::KIND_W-1:0]     kind_o,
  output logic [stq_pkg::HANDLE_W-1:0]   handle_o,
  output logic [stq_pkg::COUNT_W-1:0]    active_count_o,
  output logic                           next_valid_o,
  output logic [stq_pkg::MS_W-1:0]       next_remaining_ms_o,
  output logic                           last_o
);
  import stq_pkg::*;

  localparam int unsigned Cap = (SLOTS < MAX_HANDLES) ? SLOTS : MAX_HANDLES;
  localparam int unsigned CW  = $clog2(Cap + 1);
  localparam int unsigned EW  = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam logic [EW-1:0] TMaxE   = EW'({TIME_BITS{1'b1}});
  localparam logic [EW-1:0] MsMaxE  = EW'({MS_W{1'b1}});

  logic [TIME_BITS-1:0] rem_q [Cap];
  logic [TIME_BITS-1:0] rem_d [Cap];
  logic [TIME_BITS-1:0] rem_up [Cap];
  logic [TIME_BITS-1:0] rem_sub [Cap];
  logic [HANDLE_W-1:0]  hnd_q [Cap];
  logic [HANDLE_W-1:0]  hnd_d [Cap];
  logic [HANDLE_W-1:0]  hnd_up [Cap];

  logic [CW-1:0]          count_q, count_d;
  logic [MAX_HANDLES-1:0] free_q, free_d;
  logic [HANDLE_W-1:0]    res_hnd_q, res_hnd_d;
  logic [HANDLE_W-1:0]    free_h;

  op_e                  op_q;
  logic [TIME_BITS-1:0] dly_q;
  logic [HANDLE_W-1:0]  tgt_q;
  logic [MS_W-1:0]      elapsed_q;
  logic [EW-1:0]        dly_e;
  logic [EW-1:0]        head_e;

  logic [Cap-1:0] vld, ge, ge_prev, match, pre;
  logic [MAX_HANDLES-1:0] rel_mask;

  logic                result_valid_q;
  logic [KIND_W-1:0]   kind_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [COUNT_W-1:0]  count_out_q;
  logic                next_valid_q;
  logic [MS_W-1:0]     next_rem_q;
  logic                last_q;

  always_comb begin
    dly_e = EW'(delay_ms_i);
    if (dly_e == '0) begin
      dly_e = EW'(1);
    end else if (dly_e > TMaxE) begin
      dly_e = TMaxE;
    end
  end

  always_comb begin
    for (int i = 0; i < Cap; i++) begin
      vld[i]     = CW'(i) < count_q;
      ge[i]      = vld[i] && (rem_q[i] >= dly_q);
      match[i]   = vld[i] && (hnd_q[i] == tgt_q);
      rem_sub[i] = (EW'(rem_q[i]) <= EW'(elapsed_q)) ? '0
                 : TIME_BITS'(EW'(rem_q[i]) - EW'(elapsed_q));
    end
    ge_prev = {ge[Cap-2:0], 1'b0};
    pre[0]  = match[0];
    for (int i = 1; i < Cap; i++) begin
      pre[i] = pre[i-1] | match[i];
    end
    for (int i = 0; i < Cap - 1; i++) begin
      rem_up[i] = rem_q[i+1];
      hnd_up[i] = hnd_q[i+1];
    end
    rem_up[Cap-1] = '0;
    hnd_up[Cap-1] = '0;
  end

  always_comb begin
    free_h = '0;
    for (int i = MAX_HANDLES - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        free_h = HANDLE_W'(i);
      end
    end
    rel_mask = '0;
    for (int i = 0; i < Cap; i++) begin
      if (match[i]) begin
        rel_mask[hnd_q[i]] = 1'b1;
      end
    end
  end

  always_comb begin
    rem_d     = rem_q;
    hnd_d     = hnd_q;
    count_d   = count_q;
    free_d    = free_q;
    res_hnd_d = res_hnd_q;
    if (cmd_i.insert) begin
      for (int i = 0; i < Cap; i++) begin
        if (ge_prev[i]) begin
          rem_d[i] = rem_q[i-1 < 0 ? 0 : i-1];
          hnd_d[i] = hnd_q[i-1 < 0 ? 0 : i-1];
        end else if (ge[i] || CW'(i) == count_q) begin
          rem_d[i] = dly_q;
          hnd_d[i] = free_h;
        end
      end
      count_d          = count_q + CW'(1);
      free_d[free_h]   = 1'b0;
      res_hnd_d        = free_h;
    end else if (cmd_i.kill) begin
      for (int i = 0; i < Cap; i++) begin
        if (pre[i]) begin
          rem_d[i] = rem_up[i];
          hnd_d[i] = hnd_up[i];
        end
      end
      if (pre[Cap-1]) begin
        count_d = count_q - CW'(1);
      end
      free_d = free_q | rel_mask;
    end else if (cmd_i.sub) begin
      rem_d = rem_sub;
    end else if (cmd_i.pop) begin
      rem_d            = rem_up;
      hnd_d            = hnd_up;
      count_d          = count_q - CW'(1);
      free_d[hnd_q[0]] = 1'b1;
      res_hnd_d        = hnd_q[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      free_q         <= '1;
      result_valid_q <= 1'b0;
    end else begin
      count_q        <= count_d;
      free_q         <= free_d;
      result_valid_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    hnd_q     <= hnd_d;
    res_hnd_q <= res_hnd_d;
    if (cmd_i.load) begin
      op_q      <= op_e'(op_i);
      dly_q     <= TIME_BITS'(dly_e);
      tgt_q     <= target_handle_i;
      elapsed_q <= elapsed_ms_i;
    end
    if (cmd_i.emit) begin
      kind_q       <= cmd_i.kind;
      handle_q     <= (cmd_i.kind == K_INSTALLED || cmd_i.kind == K_FIRED) ? res_hnd_q : '0;
      count_out_q  <= COUNT_W'(count_q);
      next_valid_q <= count_q != '0;
      next_rem_q   <= (count_q == '0) ? '0
                    : (head_e > MsMaxE) ? '1 : head_e[MS_W-1:0];
      last_q       <= cmd_i.last;
    end
  end

  assign head_e = EW'(rem_q[0]);

  assign sts_o.op           = op_q;
  assign sts_o.full         = count_q == CW'(Cap);
  assign sts_o.head_expired = (count_q != '0) && (rem_q[0] == '0);

  assign result_valid_o      = result_valid_q;
  assign kind_o              = kind_q;
  assign handle_o            = handle_q;
  assign active_count_o      = count_out_q;
  assign next_valid_o        = next_valid_q;
  assign next_remaining_ms_o = next_rem_q;
  assign last_o              = last_q;

endmodule

// File: hw/rtl/stq_ctrl.sv
`timescale 1ns / 1ps

module stq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  stq_pkg::dp_sts_t sts_i,
  output stq_pkg::dp_cmd_t cmd_o,
  output logic             busy_o
);
  import stq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_REPORT
  } state_e;

  state_e state_q;
  kind_e  kind_q;
  logic   last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= K_INSTALLED;
      last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (sts_i.op)
            OP_INSTALL: begin
              kind_q  <= sts_i.full ? K_FULL : K_INSTALLED;
              last_q  <= 1'b1;
              state_q <= S_REPORT;
            end
            OP_KILL: begin
              kind_q  <= K_KILLED;
              last_q  <= 1'b1;
              state_q <= S_REPORT;
            end
            OP_TICK: begin
              state_q <= S_POP;
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_POP: begin
          kind_q  <= sts_i.head_expired ? K_FIRED : K_TICK_DONE;
          last_q  <= !sts_i.head_expired;
          state_q <= S_REPORT;
        end
        S_REPORT: begin
          state_q <= last_q ? S_IDLE : S_POP;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o.load   = (state_q == S_IDLE) && start_i;
    cmd_o.insert = (state_q == S_EXEC) && (sts_i.op == OP_INSTALL) && !sts_i.full;
    cmd_o.kill   = (state_q == S_EXEC) && (sts_i.op == OP_KILL);
    cmd_o.sub    = (state_q == S_EXEC) && (sts_i.op == OP_TICK);
    cmd_o.pop    = (state_q == S_POP) && sts_i.head_expired;
    cmd_o.emit   = state_q == S_REPORT;
    cmd_o.kind   = kind_q;
    cmd_o.last   = last_q;
  end

  assign busy_o = state_q != S_IDLE;

endmodule

// File: hw/rtl/sorted_timer_queue_core.sv
`timescale 1ns / 1ps
// Install and kill: the sequencer loads operands, runs S_EXEC, then emits from S_REPORT via the result
// register; no new item is taken until it is back in S_IDLE. Tick with F expiring timers: S_EXEC subtracts the
// elapsed time, then S_POP and S_REPORT alternate, popping and reporting one expired head per pass, until tick-done.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (async, active low): sequencer idle, table empty, all handles free, no result pending.

module sorted_timer_queue_core #(
  parameter int unsigned SLOTS     = stq_pkg::SLOTS_DEF,
  parameter int unsigned TIME_BITS = stq_pkg::TIME_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [stq_pkg::OP_W-1:0]     op_i,
  input  logic [stq_pkg::MS_W-1:0]     delay_ms_i,
  input  logic [stq_pkg::HANDLE_W-1:0] target_handle_i,
  input  logic [stq_pkg::MS_W-1:0]     elapsed_ms_i,
  output logic                         result_valid_o,
  output logic [stq_pkg::KIND_W-1:0]   kind_o,
  output logic [stq_pkg::HANDLE_W-1:0] handle_o,
  output logic [stq_pkg::COUNT_W-1:0]  active_count_o,
  output logic                         next_valid_o,
  output logic [stq_pkg::MS_W-1:0]     next_remaining_ms_o,
  output logic                         last_o
);
  import stq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    busy_int;

  stq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_int)
  );

  stq_datapath #(
    .SLOTS     (SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .op_i                (op_i),
    .delay_ms_i          (delay_ms_i),
    .target_handle_i     (target_handle_i),
    .elapsed_ms_i        (elapsed_ms_i),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .result_valid_o      (result_valid_o),
    .kind_o              (kind_o),
    .handle_o            (handle_o),
    .active_count_o      (active_count_o),
    .next_valid_o        (next_valid_o),
    .next_remaining_ms_o (next_remaining_ms_o),
    .last_o              (last_o)
  );

  assign busy = busy_int;

endmodule

// File: hw/rtl/stq_checker.sv
`timescale 1ns / 1ps

module stq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         result_valid_o,
  input logic [stq_pkg::KIND_W-1:0]   kind_o,
  input logic [stq_pkg::COUNT_W-1:0]  active_count_o,
  input logic                         next_valid_o,
  input logic [stq_pkg::MS_W-1:0]     next_remaining_ms_o,
  input logic                         last_o
);
  import stq_pkg::*;

  a_next_valid_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (next_valid_o == (active_count_o != '0)))
    else $error("next_valid disagrees with active_count");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !next_valid_o) |-> (next_remaining_ms_o == '0))
    else $error("head time nonzero with empty table");

  a_only_fired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (last_o == (kind_o != K_FIRED)))
    else $error("last flag inconsistent with result kind");

  a_more_results_keep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy)
    else $error("block idle while results remain");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (.*);
